// ===== rtl/qosa_pkg.sv =====
`timescale 1ns / 1ps

package qosa_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int CORNER_W    = 32;
    localparam int EDGE_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = EDGE_W + COORD_WIDTH;
    localparam int PROJ_W      = PROD_W + 1;
    localparam int NUM_CORNERS = 4;
    localparam int NUM_POINTS  = 2 * NUM_CORNERS;
    localparam int NUM_LANES   = 2 * NUM_CORNERS;
    localparam int NUM_STAGES  = 8;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } point_t;

    typedef point_t [NUM_CORNERS-1:0] quad_t;

    typedef struct packed {
        logic axis_en;
        logic prod_en;
        logic sum_en;
        logic pair_en;
        logic span_en;
        logic gap_en;
    } ctrl_t;

endpackage

// ===== rtl/qosa_req_if.sv =====
`timescale 1ns / 1ps

interface qosa_req_if;
    logic                            valid;
    logic                            ready;
    logic [qosa_pkg::CORNER_W-1:0]   rect_a_corner0;
    logic [qosa_pkg::CORNER_W-1:0]   rect_a_corner1;
    logic [qosa_pkg::CORNER_W-1:0]   rect_a_corner2;
    logic [qosa_pkg::CORNER_W-1:0]   rect_a_corner3;
    logic [qosa_pkg::CORNER_W-1:0]   rect_b_corner0;
    logic [qosa_pkg::CORNER_W-1:0]   rect_b_corner1;
    logic [qosa_pkg::CORNER_W-1:0]   rect_b_corner2;
    logic [qosa_pkg::CORNER_W-1:0]   rect_b_corner3;

    modport source (
        output valid, rect_a_corner0, rect_a_corner1, rect_a_corner2, rect_a_corner3,
               rect_b_corner0, rect_b_corner1, rect_b_corner2, rect_b_corner3,
        input  ready
    );

    modport sink (
        input  valid, rect_a_corner0, rect_a_corner1, rect_a_corner2, rect_a_corner3,
               rect_b_corner0, rect_b_corner1, rect_b_corner2, rect_b_corner3,
        output ready
    );
endinterface

// ===== rtl/qosa_rsp_if.sv =====
`timescale 1ns / 1ps

interface qosa_rsp_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (
        output valid, overlap,
        input  ready
    );

    modport sink (
        input  valid, overlap,
        output ready
    );
endinterface

// ===== rtl/qosa_lane.sv =====
`timescale 1ns / 1ps

module qosa_lane (
    input  logic              clk,
    input  qosa_pkg::ctrl_t   ctrl,
    input  qosa_pkg::point_t  corner_i,
    input  qosa_pkg::point_t  corner_j,
    input  qosa_pkg::quad_t   quad_a,
    input  qosa_pkg::quad_t   quad_b,
    output logic              sep
);

    logic signed [qosa_pkg::EDGE_W-1:0]      ax_next;
    logic signed [qosa_pkg::EDGE_W-1:0]      ay_next;
    logic signed [qosa_pkg::EDGE_W-1:0]      ax_reg;
    logic signed [qosa_pkg::EDGE_W-1:0]      ay_reg;
    logic signed [qosa_pkg::COORD_WIDTH-1:0] px [qosa_pkg::NUM_POINTS];
    logic signed [qosa_pkg::COORD_WIDTH-1:0] py [qosa_pkg::NUM_POINTS];
    logic signed [qosa_pkg::PROD_W-1:0]      prodx_reg [qosa_pkg::NUM_POINTS];
    logic signed [qosa_pkg::PROD_W-1:0]      prody_reg [qosa_pkg::NUM_POINTS];
    logic signed [qosa_pkg::PROJ_W-1:0]      proj_reg [qosa_pkg::NUM_POINTS];
    logic signed [qosa_pkg::PROJ_W-1:0]      lo_reg [4];
    logic signed [qosa_pkg::PROJ_W-1:0]      hi_reg [4];
    logic signed [qosa_pkg::PROJ_W-1:0]      min_a_reg;
    logic signed [qosa_pkg::PROJ_W-1:0]      max_a_reg;
    logic signed [qosa_pkg::PROJ_W-1:0]      min_b_reg;
    logic signed [qosa_pkg::PROJ_W-1:0]      max_b_reg;
    logic                                    sep_reg;

    // The axis is the edge perpendicular (-ey, ex), left unnormalized.
    always_comb
    begin
        ax_next = {corner_i.y[qosa_pkg::COORD_WIDTH-1], corner_i.y}
                - {corner_j.y[qosa_pkg::COORD_WIDTH-1], corner_j.y};
        ay_next = {corner_j.x[qosa_pkg::COORD_WIDTH-1], corner_j.x}
                - {corner_i.x[qosa_pkg::COORD_WIDTH-1], corner_i.x};
    end

    always_comb
    begin
        for (int c = 0; c < qosa_pkg::NUM_CORNERS; c++)
        begin
            px[c]                          = quad_a[c].x;
            py[c]                          = quad_a[c].y;
            px[c + qosa_pkg::NUM_CORNERS]  = quad_b[c].x;
            py[c + qosa_pkg::NUM_CORNERS]  = quad_b[c].y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.axis_en)
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
        end
        if (ctrl.prod_en)
        begin
            for (int c = 0; c < qosa_pkg::NUM_POINTS; c++)
            begin
                prodx_reg[c] <= qosa_pkg::PROD_W'(ax_reg) * qosa_pkg::PROD_W'(px[c]);
                prody_reg[c] <= qosa_pkg::PROD_W'(ay_reg) * qosa_pkg::PROD_W'(py[c]);
            end
        end
        if (ctrl.sum_en)
        begin
            for (int c = 0; c < qosa_pkg::NUM_POINTS; c++)
            begin
                proj_reg[c] <= qosa_pkg::PROJ_W'(prodx_reg[c])
                             + qosa_pkg::PROJ_W'(prody_reg[c]);
            end
        end
        if (ctrl.pair_en)
        begin
            for (int m = 0; m < 4; m++)
            begin
                lo_reg[m] <= (proj_reg[2*m] < proj_reg[2*m+1]) ? proj_reg[2*m]
                                                               : proj_reg[2*m+1];
                hi_reg[m] <= (proj_reg[2*m] < proj_reg[2*m+1]) ? proj_reg[2*m+1]
                                                               : proj_reg[2*m];
            end
        end
        if (ctrl.span_en)
        begin
            min_a_reg <= (lo_reg[0] < lo_reg[1]) ? lo_reg[0] : lo_reg[1];
            max_a_reg <= (hi_reg[0] < hi_reg[1]) ? hi_reg[1] : hi_reg[0];
            min_b_reg <= (lo_reg[2] < lo_reg[3]) ? lo_reg[2] : lo_reg[3];
            max_b_reg <= (hi_reg[2] < hi_reg[3]) ? hi_reg[3] : hi_reg[2];
        end
        if (ctrl.gap_en)
        begin
            sep_reg <= (max_a_reg < min_b_reg) || (max_b_reg < min_a_reg);
        end
    end

    assign sep = sep_reg;

endmodule

// ===== rtl/qosa_merge.sv =====
`timescale 1ns / 1ps

module qosa_merge (
    input  logic                            clk,
    input  logic                            en,
    input  logic [qosa_pkg::NUM_LANES-1:0]  sep,
    output logic                            overlap
);

    logic overlap_reg;

    // The shapes overlap unless at least one axis shows a gap.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            overlap_reg <= ~(|sep);
        end
    end

    assign overlap = overlap_reg;

endmodule

// ===== rtl/quad_overlap_separating_axis.sv =====
`timescale 1ns / 1ps

// Channel | Role | Payload
// req     | sink   | rect_a_corner0..3, rect_b_corner0..3 (x in 31:16, y in 15:0)
// rsp     | source | overlap
//
// One item is accepted per cycle unless rsp stalls; results leave from the merge stage.
// Eight axis lanes run in parallel: axis, product, sum, two min/max and gap stages.
// A stage takes a new item when it is empty or its item moves on, so bubbles collapse.
// A stall on rsp holds the pipeline; req.ready drops only once all eight stages are full.
// Reset clears the stage valid bits only.

module quad_overlap_separating_axis (
    input  logic       clk,
    input  logic       rst_n,
    qosa_req_if.sink   req,
    qosa_rsp_if.source rsp
);

    localparam int NS = qosa_pkg::NUM_STAGES;

    logic [NS-1:0]                     valid_reg;
    logic [NS-1:0]                     valid_next;
    logic [NS:0]                       adv;
    qosa_pkg::ctrl_t                   ctrl;
    qosa_pkg::quad_t                   quad_a_s0_reg;
    qosa_pkg::quad_t                   quad_b_s0_reg;
    qosa_pkg::quad_t                   quad_a_s1_reg;
    qosa_pkg::quad_t                   quad_b_s1_reg;
    qosa_pkg::quad_t                   quad_a_next;
    qosa_pkg::quad_t                   quad_b_next;
    logic [qosa_pkg::NUM_LANES-1:0]    sep;

    function automatic qosa_pkg::point_t unpack_corner(
        input logic [qosa_pkg::CORNER_W-1:0] word
    );
        qosa_pkg::point_t p;
        p.x = word[2*qosa_pkg::COORD_WIDTH-1:qosa_pkg::COORD_WIDTH];
        p.y = word[qosa_pkg::COORD_WIDTH-1:0];
        return p;
    endfunction

    always_comb
    begin
        adv[NS] = rsp.ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? req.valid : valid_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_comb
    begin
        ctrl.axis_en = adv[1];
        ctrl.prod_en = adv[2];
        ctrl.sum_en  = adv[3];
        ctrl.pair_en = adv[4];
        ctrl.span_en = adv[5];
        ctrl.gap_en  = adv[6];
    end

    always_comb
    begin
        quad_a_next[0] = unpack_corner(req.rect_a_corner0);
        quad_a_next[1] = unpack_corner(req.rect_a_corner1);
        quad_a_next[2] = unpack_corner(req.rect_a_corner2);
        quad_a_next[3] = unpack_corner(req.rect_a_corner3);
        quad_b_next[0] = unpack_corner(req.rect_b_corner0);
        quad_b_next[1] = unpack_corner(req.rect_b_corner1);
        quad_b_next[2] = unpack_corner(req.rect_b_corner2);
        quad_b_next[3] = unpack_corner(req.rect_b_corner3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            quad_a_s0_reg <= quad_a_next;
            quad_b_s0_reg <= quad_b_next;
        end
        if (adv[1])
        begin
            quad_a_s1_reg <= quad_a_s0_reg;
            quad_b_s1_reg <= quad_b_s0_reg;
        end
    end

    for (genvar l = 0; l < qosa_pkg::NUM_LANES; l++)
    begin : g_lane
        localparam int SHAPE = l / qosa_pkg::NUM_CORNERS;
        localparam int CI    = l % qosa_pkg::NUM_CORNERS;
        localparam int CJ    = (CI + 1) % qosa_pkg::NUM_CORNERS;

        qosa_pkg::point_t corner_i;
        qosa_pkg::point_t corner_j;

        assign corner_i = (SHAPE == 0) ? quad_a_s0_reg[CI] : quad_b_s0_reg[CI];
        assign corner_j = (SHAPE == 0) ? quad_a_s0_reg[CJ] : quad_b_s0_reg[CJ];

        qosa_lane u_lane (
            .clk      (clk),
            .ctrl     (ctrl),
            .corner_i (corner_i),
            .corner_j (corner_j),
            .quad_a   (quad_a_s1_reg),
            .quad_b   (quad_b_s1_reg),
            .sep      (sep[l])
        );
    end

    qosa_merge u_merge (
        .clk     (clk),
        .en      (adv[NS-1]),
        .sep     (sep),
        .overlap (rsp.overlap)
    );

    assign req.ready = adv[0];
    assign rsp.valid = valid_reg[NS-1];

`ifndef SYNTH
    a_ready_low_only_when_full : assert property (
        @(posedge clk) disable iff (!rst_n)
        !req.ready |-> (rsp.valid && !rsp.ready)
    ) else $error("Input stalled while the pipeline has room.");

    a_accept_fills_first_stage : assert property (
        @(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> valid_reg[0]
    ) else $error("Accepted item did not enter the first stage.");

    a_gap_stage_reaches_output : assert property (
        @(posedge clk) disable iff (!rst_n)
        (valid_reg[NS-2] && adv[NS-1]) |=> rsp.valid
    ) else $error("Item in the gap stage did not reach the output.");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_ITEMS = 1350;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 16;

    class overlap_scoreboard;
        bit verdicts[$];
        int errors;
        int overlaps;
        int separates;

        function void span_of(qosa_pkg::quad_t q, longint ax, longint ay,
                              output longint lo, output longint hi);
            longint dot;
            for (int k = 0; k < qosa_pkg::NUM_CORNERS; k++)
            begin
                dot = ax * longint'($signed(q[k].x)) + ay * longint'($signed(q[k].y));
                if (k == 0 || dot < lo)
                    lo = dot;
                if (k == 0 || dot > hi)
                    hi = dot;
            end
        endfunction

        function bit sat_overlap(qosa_pkg::quad_t a, qosa_pkg::quad_t b);
            qosa_pkg::quad_t shapes[2];
            longint          ex, ey, lo_a, hi_a, lo_b, hi_b;
            int              j;
            shapes[0] = a;
            shapes[1] = b;
            for (int s = 0; s < 2; s++)
            begin
                for (int i = 0; i < qosa_pkg::NUM_CORNERS; i++)
                begin
                    j  = (i + 1) % qosa_pkg::NUM_CORNERS;
                    ex = longint'($signed(shapes[s][j].x))
                       - longint'($signed(shapes[s][i].x));
                    ey = longint'($signed(shapes[s][j].y))
                       - longint'($signed(shapes[s][i].y));
                    span_of(a, -ey, ex, lo_a, hi_a);
                    span_of(b, -ey, ex, lo_b, hi_b);
                    if (hi_a < lo_b || hi_b < lo_a)
                        return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_request(qosa_pkg::quad_t a, qosa_pkg::quad_t b);
            verdicts.push_back(sat_overlap(a, b));
        endfunction

        function void check_result(bit got);
            bit want;
            if (verdicts.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got overlap=%0b", $time, got);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            if (got)
                overlaps++;
            else
                separates++;
            if (got !== want)
            begin
                $display("%0t: overlap mismatch, expected %0b, got %0b", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return verdicts.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   req_idle_pct;
    int   rsp_idle_pct;
    bit   hold_rsp;
    int   cycle_count;

    overlap_scoreboard sb;

    qosa_req_if req_if ();
    qosa_rsp_if rsp_if ();

    quad_overlap_separating_axis u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #1 clk = ~clk;

    function automatic qosa_pkg::point_t pt(int x, int y);
        qosa_pkg::point_t p;
        p.x = x[qosa_pkg::COORD_WIDTH-1:0];
        p.y = y[qosa_pkg::COORD_WIDTH-1:0];
        return p;
    endfunction

    function automatic qosa_pkg::quad_t quad_of(int x0, int y0, int x1, int y1,
                                                int x2, int y2, int x3, int y3);
        qosa_pkg::quad_t q;
        q[0] = pt(x0, y0);
        q[1] = pt(x1, y1);
        q[2] = pt(x2, y2);
        q[3] = pt(x3, y3);
        return q;
    endfunction

    function automatic qosa_pkg::quad_t box(int x0, int y0, int x1, int y1);
        return quad_of(x0, y0, x1, y0, x1, y1, x0, y1);
    endfunction

    function automatic qosa_pkg::quad_t rect_quad(int cx, int cy, int ux, int uy,
                                                  int ha, int hb, int start, bit flip);
        qosa_pkg::quad_t  q;
        qosa_pkg::point_t pts[4];
        int               sa[4];
        int               sbv[4];
        sa  = '{1, -1, -1, 1};
        sbv = '{1, 1, -1, -1};
        for (int k = 0; k < 4; k++)
            pts[k] = pt(cx + sa[k] * ha * ux - sbv[k] * hb * uy,
                        cy + sa[k] * ha * uy + sbv[k] * hb * ux);
        for (int k = 0; k < 4; k++)
            q[k] = pts[(start + (flip ? 4 - k : k)) % 4];
        return q;
    endfunction

    task automatic send_shapes(input qosa_pkg::quad_t a, input qosa_pkg::quad_t b);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid          <= 1'b1;
        req_if.rect_a_corner0 <= a[0];
        req_if.rect_a_corner1 <= a[1];
        req_if.rect_a_corner2 <= a[2];
        req_if.rect_a_corner3 <= a[3];
        req_if.rect_b_corner0 <= b[0];
        req_if.rect_b_corner1 <= b[1];
        req_if.rect_b_corner2 <= b[2];
        req_if.rect_b_corner3 <= b[3];
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_request(a, b);
        @(negedge clk);
    endtask

    task automatic send_random_pair();
        qosa_pkg::quad_t a, b;
        int              kind, ox, oy, cx, cy;
        kind = $urandom_range(99);
        ox   = int'($urandom_range(60000)) - 30000;
        oy   = int'($urandom_range(60000)) - 30000;
        if (kind < 20)
        begin
            a = {$urandom, $urandom, $urandom, $urandom};
            b = {$urandom, $urandom, $urandom, $urandom};
        end
        else if (kind < 60)
        begin
            cx = ox + (int'($urandom_range(6)) - 3) * 16;
            cy = oy + (int'($urandom_range(6)) - 3) * 16;
            a = rect_quad(ox, oy, 16, 0, $urandom_range(4), $urandom_range(4),
                          $urandom_range(3), 1'($urandom_range(1)));
            b = rect_quad(cx, cy, 16, 0, $urandom_range(4), $urandom_range(4),
                          $urandom_range(3), 1'($urandom_range(1)));
        end
        else
        begin
            cx = ox + int'($urandom_range(300)) - 150;
            cy = oy + int'($urandom_range(300)) - 150;
            a = rect_quad(ox, oy, int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8,
                          $urandom_range(10), $urandom_range(10),
                          $urandom_range(3), 1'($urandom_range(1)));
            b = rect_quad(cx, cy, int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8,
                          $urandom_range(10), $urandom_range(10),
                          $urandom_range(3), 1'($urandom_range(1)));
        end
        send_shapes(a, b);
    endtask

    task automatic run_directed();
        qosa_pkg::quad_t diamond_sep, diamond_touch, triangle, bowtie;
        diamond_sep   = quad_of(26, 14, 38, 26, 26, 38, 14, 26);
        diamond_touch = quad_of(22, 10, 34, 22, 22, 34, 10, 22);
        triangle      = quad_of(0, 0, 0, 0, 32, 0, 0, 32);
        bowtie        = quad_of(0, 0, 32, 32, 32, 0, 0, 32);
        send_shapes(box(0, 0, 0, 0), box(0, 0, 0, 0));
        send_shapes(box(32767, 32767, 32767, 32767), box(-32768, -32768, -32768, -32768));
        send_shapes(box(-32768, -32768, 32767, 32767), box(-32768, -32768, 32767, 32767));
        send_shapes(box(-32768, -32768, 32767, 32767), box(32767, 32767, 32767, 32767));
        send_shapes(quad_of(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768),
                    box(32767, -32768, -32768, 32767));
        send_shapes(box(0, 0, 16, 16), box(16, 0, 32, 16));
        send_shapes(box(0, 0, 16, 16), box(17, 0, 33, 16));
        send_shapes(box(0, 0, 16, 16), box(16, 16, 32, 32));
        send_shapes(box(0, 0, 16, 16), box(17, 17, 32, 32));
        send_shapes(box(0, 0, 16, 16), diamond_sep);
        send_shapes(diamond_sep, box(0, 0, 16, 16));
        send_shapes(box(0, 0, 16, 16), diamond_touch);
        send_shapes(triangle, box(100, 100, 140, 140));
        send_shapes(triangle, box(8, 8, 12, 12));
        send_shapes(bowtie, box(40, 0, 60, 10));
        send_shapes(bowtie, box(10, 12, 20, 14));
        send_shapes(box(-100, -80, -20, -10), box(-30, -20, 50, 60));
        send_shapes(box(-100, -80, -20, -10), box(-19, -20, 50, 60));
        send_shapes(box(-1000, -1000, 1000, 1000), box(-1, -1, 1, 1));
        send_shapes(qosa_pkg::quad_t'({4{32'hAAAA5555}}),
                    qosa_pkg::quad_t'({4{32'h5555AAAA}}));
        send_shapes(qosa_pkg::quad_t'({32'hFFFF0000, 32'h0000FFFF,
                                       32'h80007FFF, 32'h7FFF8000}),
                    qosa_pkg::quad_t'({32'h00010001, 32'hFFFFFFFF,
                                       32'h7FFF7FFF, 32'h80008000}));
        send_shapes(box(16, 16, 0, 0), box(0, 16, 16, 0));
    endtask

    initial
    begin
        bit held;
        held         = 1'b0;
        rsp_if.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_rsp && !held)
            begin
                held = 1'b1;
                rsp_if.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
            end
            else
            begin
                rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
                @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.overlap);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        sb                    = new();
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        req_idle_pct          = 0;
        rsp_idle_pct          = 0;
        hold_rsp              = 1'b0;
        req_if.valid          = 1'b0;
        req_if.rect_a_corner0 = '0;
        req_if.rect_a_corner1 = '0;
        req_if.rect_a_corner2 = '0;
        req_if.rect_a_corner3 = '0;
        req_if.rect_b_corner0 = '0;
        req_if.rect_b_corner1 = '0;
        req_if.rect_b_corner2 = '0;
        req_if.rect_b_corner3 = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        req_idle_pct = 20;
        rsp_idle_pct = 82;
        run_directed();
        for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            send_random_pair();

        req_idle_pct = 82;
        rsp_idle_pct = 20;
        for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            send_random_pair();

        req_idle_pct = 0;
        rsp_idle_pct = 0;
        hold_rsp     = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); n++)
            send_random_pair();
        req_if.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d shape pairs: %0d overlapping or touching, %0d separate.",
                 sb.overlaps + sb.separates, sb.overlaps, sb.separates);
        $display("Pacing covered slow sender, slow receiver, full rate and a long output stall.");
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/qosa_pkg.sv
rtl/qosa_req_if.sv
rtl/qosa_rsp_if.sv
rtl/qosa_lane.sv
rtl/qosa_merge.sv
rtl/quad_overlap_separating_axis.sv
test/tb_top.sv
